// File: rtl/abr_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and the rate clamp and preset lookup functions for the
// adaptive bitrate controller. No dependencies.
package abr_pkg;

	localparam int RateW  = 16;
	localparam int LossW  = 8;
	localparam int CountW = 8;
	localparam int LevelW = 2;
	localparam int CfgW   = 64;
	localparam int CfgIdxW = 3;

	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_STEADY_MAX    = 3'd0,
		REG_STEADY_MIN    = 3'd1,
		REG_CONG_MAX      = 3'd2,
		REG_CONG_MIN      = 3'd3,
		REG_STEP_SIZES    = 3'd4,
		REG_PRESET_RATES  = 3'd5,
		REG_STEADY_AFTER  = 3'd6,
		REG_MODE_FLAGS    = 3'd7
	} cfg_idx_t;

	typedef enum logic [LevelW-1:0] {
		LEVEL_LOW  = 2'd0,
		LEVEL_MED  = 2'd1,
		LEVEL_HIGH = 2'd2
	} level_t;

	typedef struct packed {
		logic [RateW-1:0]  steady_max;
		logic [RateW-1:0]  steady_min;
		logic [RateW-1:0]  cong_max;
		logic [RateW-1:0]  cong_min;
		logic [63:0]       step_sizes;
		logic [47:0]       preset_rates;
		logic [CountW-1:0] steady_after;
		logic [1:0]        mode_flags;
	} cfg_t;

	typedef struct packed {
		logic [RateW-1:0]  rate;
		level_t            level;
		logic              congested;
		logic [CountW-1:0] clean_count;
	} abr_state_t;

	typedef struct packed {
		logic [RateW-1:0] est_kbps;
		logic [RateW-1:0] enc_kbps;
		logic [LossW-1:0] loss;
	} report_t;

	typedef struct packed {
		logic              overrun;
		logic              congested;
		logic [LevelW-1:0] level;
		logic [RateW-1:0]  bitrate;
	} result_t;

	localparam logic [RateW-1:0]  SteadyMaxRst   = 16'd6000;
	localparam logic [RateW-1:0]  SteadyMinRst   = 16'd1000;
	localparam logic [RateW-1:0]  CongMaxRst     = 16'd2500;
	localparam logic [RateW-1:0]  CongMinRst     = 16'd250;
	localparam logic [CountW-1:0] SteadyAfterRst = 8'd10;
	localparam logic [1:0]        ModeFlagsRst   = 2'd1;

	// Take the candidate when it lies inside [lo, hi]; otherwise pull the
	// current rate back into range or hold it.
	function automatic logic [RateW-1:0] apply_rate(
		input logic             neg,
		input logic [RateW:0]   cand,
		input logic [RateW-1:0] cur,
		input logic [RateW-1:0] lo,
		input logic [RateW-1:0] hi
	);
		logic [RateW-1:0] res;
		if (!neg && cand >= {1'b0, lo} && cand <= {1'b0, hi}) begin
			res = cand[RateW-1:0];
		end else if (cur > hi) begin
			res = hi;
		end else if (cur < lo) begin
			res = lo;
		end else begin
			res = cur;
		end
		return res;
	endfunction

	function automatic logic [RateW-1:0] preset_of(
		input logic [47:0] presets,
		input level_t      lvl
	);
		logic [RateW-1:0] res;
		unique case (lvl)
			LEVEL_LOW:  res = presets[15:0];
			LEVEL_MED:  res = presets[31:16];
			LEVEL_HIGH: res = presets[47:32];
			default:    res = presets[15:0];
		endcase
		return res;
	endfunction

endpackage

// File: rtl/abr_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the adaptive bitrate controller.
// Depends on abr_pkg.
module abr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [abr_pkg::CfgW-1:0]      cfg_wdata,
	output abr_pkg::cfg_t                 cfg
);
	import abr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steady_max   <= SteadyMaxRst;
			cfg_q.steady_min   <= SteadyMinRst;
			cfg_q.cong_max     <= CongMaxRst;
			cfg_q.cong_min     <= CongMinRst;
			cfg_q.step_sizes   <= '0;
			cfg_q.preset_rates <= '0;
			cfg_q.steady_after <= SteadyAfterRst;
			cfg_q.mode_flags   <= ModeFlagsRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_STEADY_MAX:   cfg_q.steady_max   <= cfg_wdata[RateW-1:0];
				REG_STEADY_MIN:   cfg_q.steady_min   <= cfg_wdata[RateW-1:0];
				REG_CONG_MAX:     cfg_q.cong_max     <= cfg_wdata[RateW-1:0];
				REG_CONG_MIN:     cfg_q.cong_min     <= cfg_wdata[RateW-1:0];
				REG_STEP_SIZES:   cfg_q.step_sizes   <= cfg_wdata[63:0];
				REG_PRESET_RATES: cfg_q.preset_rates <= cfg_wdata[47:0];
				REG_STEADY_AFTER: cfg_q.steady_after <= cfg_wdata[CountW-1:0];
				REG_MODE_FLAGS:   cfg_q.mode_flags   <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/abr_update.sv
`timescale 1ns / 1ps
// Combinational state update for one link report: mode, limits, rate step,
// resolution move and result. Depends on abr_pkg.
module abr_update (
	input  abr_pkg::cfg_t       cfg,
	input  abr_pkg::abr_state_t cur,
	input  abr_pkg::report_t    rpt,
	output abr_pkg::abr_state_t nxt,
	output abr_pkg::result_t    res
);
	import abr_pkg::*;

	logic             cong_eff;
	logic [RateW-1:0] lim_max, lim_min, step_up, step_dn;
	logic             lossy, overrun, go_down;
	logic [RateW:0]   cand;
	logic             cand_neg;
	logic [RateW-1:0] rate1, rate2;
	logic [RateW-1:0] p0, p1, p2;
	logic             move;
	level_t           new_level;
	logic [RateW+1:0] enc_x2, est_x3;

	assign p0 = cfg.preset_rates[15:0];
	assign p1 = cfg.preset_rates[31:16];
	assign p2 = cfg.preset_rates[47:32];

	// 1.5x overrun check done exactly as 2*enc >= 3*est
	assign enc_x2  = {1'b0, rpt.enc_kbps, 1'b0};
	assign est_x3  = {1'b0, rpt.est_kbps, 1'b0} + {2'b00, rpt.est_kbps};
	assign overrun = cfg.mode_flags[0] && (enc_x2 >= est_x3);

	assign lossy    = (rpt.loss != '0);
	assign go_down  = lossy || overrun;
	assign cong_eff = (cur.clean_count >= cfg.steady_after) ? 1'b0 : cur.congested;

	always_comb begin
		if (cong_eff) begin
			lim_max = cfg.cong_max;
			lim_min = cfg.cong_min;
			step_up = cfg.step_sizes[47:32];
			step_dn = cfg.step_sizes[63:48];
		end else begin
			lim_max = cfg.steady_max;
			lim_min = cfg.steady_min;
			step_up = cfg.step_sizes[15:0];
			step_dn = cfg.step_sizes[31:16];
		end
	end

	always_comb begin
		if (go_down) begin
			cand     = {1'b0, cur.rate} - {1'b0, step_dn};
			cand_neg = cand[RateW];
		end else begin
			cand     = {1'b0, cur.rate} + {1'b0, step_up};
			cand_neg = 1'b0;
		end
	end

	assign rate1 = apply_rate(cand_neg, cand, cur.rate, lim_min, lim_max);

	always_comb begin
		move      = 1'b0;
		new_level = cur.level;
		if (go_down) begin
			if (cur.level == LEVEL_HIGH && rate1 < p1) begin
				move      = 1'b1;
				new_level = LEVEL_MED;
			end else if (cur.level == LEVEL_MED && rate1 < p0) begin
				move      = 1'b1;
				new_level = LEVEL_LOW;
			end
		end else begin
			if (cur.level == LEVEL_LOW && rate1 > p1) begin
				move      = 1'b1;
				new_level = LEVEL_MED;
			end else if (cur.level == LEVEL_MED && rate1 > p2) begin
				move      = 1'b1;
				new_level = LEVEL_HIGH;
			end
		end
		// hold the level when resolution is pinned
		if (cfg.mode_flags[1]) begin
			move      = 1'b0;
			new_level = cur.level;
		end
	end

	// reload the new level's preset through the same clamp
	assign rate2 = move
		? apply_rate(1'b0, {1'b0, preset_of(cfg.preset_rates, new_level)},
			rate1, lim_min, lim_max)
		: rate1;

	always_comb begin
		nxt.rate      = rate2;
		nxt.level     = new_level;
		nxt.congested = lossy ? 1'b1 : cong_eff;
		if (lossy) begin
			nxt.clean_count = '0;
		end else if (cur.clean_count != CountMax) begin
			nxt.clean_count = cur.clean_count + 1'b1;
		end else begin
			nxt.clean_count = cur.clean_count;
		end
	end

	assign res.bitrate   = rate2;
	assign res.level     = new_level;
	assign res.congested = nxt.congested;
	assign res.overrun   = overrun;

endmodule

// File: rtl/adaptive_bitrate_controller.sv
`timescale 1ns / 1ps
// Top level of the adaptive bitrate controller: input register, state and
// result register around abr_update. Depends on abr_pkg, abr_cfg_regs, abr_update.

// One link report in, one result out. A report is registered on acceptance,
// processed when the result register is free or being emptied (state and
// result register load together) and offered on the master side from there.
// A new report can be taken every cycle while the sink does not stall. The
// whole state update is a single pass of adds and compares between the report
// register and the result register; the result register lets the next report
// enter while a result still waits for the sink. No clearing pass after reset.
module adaptive_bitrate_controller (
	input  logic        clk,
	input  logic        arst_n,
	// input reports
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // loss_fraction[7:0], encoder_rate_kbps[23:8],
	                                   // estimated_rate_kbps[39:24]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // bitrate_kbps[15:0], resolution_level[17:16],
	                                   // congested[18], overrun_warning[19], zero[23:20]
	// configuration
	input  logic                          cfg_we,
	input  logic [abr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [abr_pkg::CfgW-1:0]      cfg_wdata
);
	import abr_pkg::*;

	cfg_t       cfg;
	report_t    rpt_s1;
	logic       valid_s1;
	abr_state_t state_q, state_nxt;
	result_t    res_nxt, res_s2;
	logic       valid_s2;
	logic       advance;

	abr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	abr_update u_update (
		.cfg (cfg),
		.cur (state_q),
		.rpt (rpt_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// move the held report into the result stage when that stage frees up
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rpt_s1 <= report_t'(s_axis_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rate        <= '0;
			state_q.level       <= LEVEL_LOW;
			state_q.congested   <= 1'b0;
			state_q.clean_count <= '0;
			valid_s2            <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, res_s2};

`ifndef SYNTHESIS
	a_level_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.level != 2'd3)
		else $error("resolution level left its range");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty report register");

	a_lossy_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rpt_s1.loss != '0 |=> state_q.clean_count == '0 && state_q.congested)
		else $error("lossy report did not clear run count or set congested");

	a_clean_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rpt_s1.loss == '0 |=> state_q.clean_count != '0)
		else $error("loss-free report did not advance run count");

	a_fixed_level: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cfg.mode_flags[1] |=> state_q.level == $past(state_q.level))
		else $error("level moved while resolution is fixed");

	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_s2.bitrate == state_q.rate && res_s2.level == state_q.level)
		else $error("result disagrees with stored state");
`endif

endmodule

// File: bench/abr_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the adaptive bitrate controller: watches the report, result and
// register write channels, predicts each result and compares it. Depends on abr_pkg.
module abr_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [39:0]                   s_axis_tdata,  // loss, enc kbps, est kbps
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [23:0]                   m_axis_tdata,  // bitrate, level, congested,
	                                                     // overrun, zero
	input  logic                          cfg_we,
	input  logic [abr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [abr_pkg::CfgW-1:0]      cfg_wdata,
	output int                            errors,
	output int                            outstanding
);
	import abr_pkg::*;

	cfg_t              regs;
	logic [RateW-1:0]  rate;
	level_t            level;
	logic              congested;
	logic [CountW-1:0] clean_run;
	result_t           pending_decisions[$];

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40) begin
			$display("%0t abr check: %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	function automatic logic [RateW-1:0] preset_kbps(input logic [47:0] presets,
			input level_t lvl);
		return presets[16*int'(lvl) +: 16];
	endfunction

	// Take the candidate only inside [lo, hi]; else pull the rate back into range or hold it.
	function automatic logic [RateW-1:0] limit_rate(input longint cand,
			input logic [RateW-1:0] cur, input logic [RateW-1:0] lo,
			input logic [RateW-1:0] hi);
		if (cand >= longint'(lo) && cand <= longint'(hi)) begin
			return cand[RateW-1:0];
		end else if (cur > hi) begin
			return hi;
		end else if (cur < lo) begin
			return lo;
		end
		return cur;
	endfunction

	task automatic move_to(input level_t lvl, input logic [RateW-1:0] lo,
			input logic [RateW-1:0] hi);
		if (regs.mode_flags[1]) begin
			return;
		end
		rate = limit_rate(longint'(preset_kbps(regs.preset_rates, lvl)), rate, lo, hi);
		level = lvl;
	endtask

	task automatic advance_controller(input report_t r, output result_t res);
		logic [RateW-1:0] lo, hi, up, down;
		logic overrun, going_up;
		overrun = regs.mode_flags[0] && (2 * int'(r.enc_kbps) >= 3 * int'(r.est_kbps));
		if (clean_run >= regs.steady_after) begin
			congested = 1'b0;
		end
		// limits and steps stay those of the mode at the start of the report
		if (!congested) begin
			hi   = regs.steady_max;
			lo   = regs.steady_min;
			up   = regs.step_sizes[15:0];
			down = regs.step_sizes[31:16];
		end else begin
			hi   = regs.cong_max;
			lo   = regs.cong_min;
			up   = regs.step_sizes[47:32];
			down = regs.step_sizes[63:48];
		end
		going_up = (r.loss == '0) && !overrun;
		if (r.loss != '0) begin
			congested = 1'b1;
			clean_run = '0;
		end else if (clean_run != CountMax) begin
			clean_run++;
		end
		if (going_up) begin
			rate = limit_rate(longint'(rate) + longint'(up), rate, lo, hi);
			if (level == LEVEL_LOW && rate > preset_kbps(regs.preset_rates, LEVEL_MED)) begin
				move_to(LEVEL_MED, lo, hi);
			end else if (level == LEVEL_MED &&
					rate > preset_kbps(regs.preset_rates, LEVEL_HIGH)) begin
				move_to(LEVEL_HIGH, lo, hi);
			end
		end else begin
			rate = limit_rate(longint'(rate) - longint'(down), rate, lo, hi);
			if (level == LEVEL_HIGH && rate < preset_kbps(regs.preset_rates, LEVEL_MED)) begin
				move_to(LEVEL_MED, lo, hi);
			end else if (level == LEVEL_MED &&
					rate < preset_kbps(regs.preset_rates, LEVEL_LOW)) begin
				move_to(LEVEL_LOW, lo, hi);
			end
		end
		res.bitrate   = rate;
		res.level     = level;
		res.congested = congested;
		res.overrun   = overrun;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got, want;
		if (!arst_n) begin
			regs.steady_max   = SteadyMaxRst;
			regs.steady_min   = SteadyMinRst;
			regs.cong_max     = CongMaxRst;
			regs.cong_min     = CongMinRst;
			regs.step_sizes   = '0;
			regs.preset_rates = '0;
			regs.steady_after = SteadyAfterRst;
			regs.mode_flags   = ModeFlagsRst;
			rate        = preset_kbps(regs.preset_rates, LEVEL_LOW);
			level       = LEVEL_LOW;
			congested   = 1'b0;
			clean_run   = '0;
			pending_decisions.delete();
			outstanding = 0;
			errors      = 0;
		end else begin
			// compare before predicting, so a same-edge report is never matched early
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[19:0]);
				if (pending_decisions.size() == 0) begin
					report_mismatch("result with no report waiting", int'(got.bitrate), -1);
				end else begin
					want = pending_decisions.pop_front();
					if (got.bitrate != want.bitrate)
						report_mismatch("bitrate_kbps", int'(got.bitrate),
							int'(want.bitrate));
					if (got.level != want.level)
						report_mismatch("resolution_level", int'(got.level),
							int'(want.level));
					if (got.congested != want.congested)
						report_mismatch("congested", int'(got.congested),
							int'(want.congested));
					if (got.overrun != want.overrun)
						report_mismatch("overrun_warning", int'(got.overrun),
							int'(want.overrun));
					if (m_axis_tdata[23:20] != '0)
						report_mismatch("padding bits", int'(m_axis_tdata[23:20]), 0);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_STEADY_MAX:   regs.steady_max   = cfg_wdata[15:0];
					REG_STEADY_MIN:   regs.steady_min   = cfg_wdata[15:0];
					REG_CONG_MAX:     regs.cong_max     = cfg_wdata[15:0];
					REG_CONG_MIN:     regs.cong_min     = cfg_wdata[15:0];
					REG_STEP_SIZES:   regs.step_sizes   = cfg_wdata;
					REG_PRESET_RATES: regs.preset_rates = cfg_wdata[47:0];
					REG_STEADY_AFTER: regs.steady_after = cfg_wdata[7:0];
					REG_MODE_FLAGS:   regs.mode_flags   = cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_controller(report_t'(s_axis_tdata), want);
				pending_decisions.push_back(want);
			end
			outstanding = pending_decisions.size();
		end
	end

endmodule

// File: bench/tb_adaptive_bitrate_controller.sv
`timescale 1ns / 1ps
// Testbench top for the adaptive bitrate controller: clock, reset, report stimulus,
// sink pacing and register phases. Depends on abr_pkg and abr_result_checker.
module tb_adaptive_bitrate_controller;
	import abr_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [39:0]        s_axis_tdata = '0;  // loss[7:0], enc kbps[23:8], est kbps[39:24]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [23:0]        m_axis_tdata;       // bitrate[15:0], level[17:16], congested[18],
	                                        // overrun[19], zero[23:20]
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_wdata = '0;

	int errors;
	int outstanding;
	bit steady_flow = 1'b0;
	int sink_hold = 0;

	adaptive_bitrate_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	abr_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("tb_adaptive_bitrate_controller: errors");
		$finish;
	end

	function automatic report_t link_report(input int loss, input int enc, input int est);
		report_t r;
		r.loss     = 8'(loss);
		r.enc_kbps = 16'(enc);
		r.est_kbps = 16'(est);
		return r;
	endfunction

	function automatic report_t random_report(input int loss_pct);
		report_t r;
		int est;
		est = $urandom_range(0, 65535);
		r.enc_kbps = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 2))
			0: ;
			// land around the 1.5x overrun boundary
			1: begin
				est = $urandom_range(0, 43690);
				r.enc_kbps = 16'((3 * est + 1) / 2 - 1 + $urandom_range(0, 2));
			end
			default: r.enc_kbps = 16'($urandom_range(0, est));
		endcase
		r.est_kbps = 16'(est);
		r.loss = ($urandom_range(0, 99) < loss_pct) ? 8'($urandom_range(1, 255)) : 8'd0;
		return r;
	endfunction

	function automatic cfg_t pick_config(input int phase);
		cfg_t c;
		c.steady_min   = 16'($urandom_range(0, 2000));
		c.steady_max   = c.steady_min + 16'($urandom_range(0, 20000));
		c.cong_min     = 16'($urandom_range(0, 1000));
		c.cong_max     = c.cong_min + 16'($urandom_range(0, 8000));
		c.step_sizes   = {16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
		                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500))};
		if (phase % 4 == 0)
			c.step_sizes = {$urandom, $urandom};
		c.preset_rates[15:0]  = 16'($urandom_range(0, 3000));
		c.preset_rates[31:16] = c.preset_rates[15:0] + 16'($urandom_range(0, 6000));
		c.preset_rates[47:32] = c.preset_rates[31:16] + 16'($urandom_range(0, 10000));
		c.steady_after = 8'($urandom_range(0, 20));
		c.mode_flags   = 2'($urandom_range(0, 3));
		case (phase)
			0: c = '0;
			1: c = '1;
			// lower limits above upper limits
			2: begin
				c.steady_max = 16'($urandom_range(0, 3000));
				c.steady_min = c.steady_max + 16'($urandom_range(1, 3000));
				c.cong_max   = 16'($urandom_range(0, 3000));
				c.cong_min   = c.cong_max + 16'($urandom_range(1, 3000));
			end
			// long loss-free run with steady_after at the clean count's maximum
			3: begin
				c.steady_after = CountMax;
				c.mode_flags   = 2'd0;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// Fill unused upper bits with junk; the block must drop them.
	task automatic program_config(input cfg_t c);
		logic [CfgW-1:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_STEADY_MAX, {junk[63:16], c.steady_max});
		write_reg(REG_STEADY_MIN, {junk[63:16], c.steady_min});
		write_reg(REG_CONG_MAX, {junk[63:16], c.cong_max});
		write_reg(REG_CONG_MIN, {junk[63:16], c.cong_min});
		write_reg(REG_STEP_SIZES, c.step_sizes);
		write_reg(REG_PRESET_RATES, {junk[63:48], c.preset_rates});
		write_reg(REG_STEADY_AFTER, {junk[63:8], c.steady_after});
		write_reg(REG_MODE_FLAGS, {junk[63:2], c.mode_flags});
		cfg_we <= 1'b0;
	endtask

	task automatic send_report(input report_t r);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted result has been taken.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin : sink
		int stall;
		@(negedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end else begin
				stall = steady_flow ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		cfg_t cfg;
		int loss_pct;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero steps and presets
		send_report(link_report(0, 0, 0));
		send_report(link_report(0, 1000, 2000));
		send_report(link_report(0, 1000, 2000));
		send_report(link_report(1, 0, 0));
		send_report(link_report(0, 65535, 0));
		send_report(link_report(255, 65535, 65535));
		send_report(link_report(0, 43690, 29127));
		send_report(link_report(0, 43691, 29127));
		wait_idle();

		cfg.steady_max   = 16'd6000;
		cfg.steady_min   = 16'd1000;
		cfg.cong_max     = 16'd2500;
		cfg.cong_min     = 16'd250;
		cfg.step_sizes   = {16'd400, 16'd100, 16'd500, 16'd300};
		cfg.preset_rates = {16'd4000, 16'd2000, 16'd800};
		cfg.steady_after = 8'd3;
		cfg.mode_flags   = 2'd1;
		program_config(cfg);
		repeat (5) send_report(link_report(0, 100, 1000));
		send_report(link_report(0, 3000, 2000));
		send_report(link_report(8'h80, 100, 1000));
		send_report(link_report(1, 100, 1000));
		repeat (6) send_report(link_report(0, 100, 1000));
		send_report(link_report(8'hFF, 0, 0));
		send_report(link_report(8'h7F, 65535, 65535));
		send_report(link_report(0, 0, 0));
		wait_idle();

		// back the block up against a stalled sink
		steady_flow = 1'b1;
		sink_hold = 60;
		repeat (20) send_report(random_report(20));
		steady_flow = 1'b0;
		wait_idle();

		for (int phase = 0; phase < 12; phase++) begin
			cfg = pick_config(phase);
			program_config(cfg);
			steady_flow = (phase % 3 == 2);
			if (phase == 3)
				loss_pct = 0;
			else if (phase < 2)
				loss_pct = 30;
			else
				loss_pct = (phase % 2 == 0) ? 10 : 35;
			for (int i = 0; i < 135; i++) begin
				send_report(random_report(loss_pct));
				if (phase == 5 && i == 60)
					wait_idle();
			end
			wait_idle();
		end

		repeat (8) @(negedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("tb_adaptive_bitrate_controller: clean");
		end else begin
			$display("tb_adaptive_bitrate_controller: errors");
		end
		$finish;
	end

endmodule
